### hdl/lfps_pkg.sv
`timescale 1ns / 1ps

package lfps_pkg;

   // register map, byte address = 8 * index
   localparam logic [2:0] REG_TARGET_POS  = 3'd0;
   localparam logic [2:0] REG_KP_GAIN     = 3'd1;
   localparam logic [2:0] REG_KI_GAIN     = 3'd2;
   localparam logic [2:0] REG_KD_GAIN     = 3'd3;
   localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;
   localparam logic [2:0] REG_OUT_LIMIT   = 3'd5;

   localparam logic signed [3:0] TARGET_POS_RST  = 4'sd0;
   localparam logic [31:0]       KP_GAIN_RST     = 32'd61603840;
   localparam logic [39:0]       KI_GAIN_RST     = 40'd24189;
   localparam logic [31:0]       KD_GAIN_RST     = 32'd0;
   localparam logic [15:0]       INTEG_LIMIT_RST = 16'd550;
   localparam logic [15:0]       OUT_LIMIT_RST   = 16'd2000;

   // line position per sensor, half units
   localparam logic signed [3:0] POS_S1 = -4'sd4;
   localparam logic signed [3:0] POS_S2 = -4'sd2;
   localparam logic signed [3:0] POS_S3 = 4'sd0;
   localparam logic signed [3:0] POS_S4 = 4'sd3;
   localparam logic signed [3:0] POS_S5 = 4'sd4;

   // step counts minus one for the shift-add and divide loops
   localparam logic [5:0] STEPS_KI  = 6'd19;
   localparam logic [5:0] STEPS_E   = 6'd3;
   localparam logic [5:0] STEPS_KP  = 6'd3;
   localparam logic [5:0] STEPS_KD  = 6'd4;
   localparam logic [5:0] STEPS_DIV = 6'd36;

   typedef struct packed {
      logic signed [3:0] target_pos;
      logic [31:0]       kp_gain;
      logic [39:0]       ki_gain;
      logic [31:0]       kd_gain;
      logic [15:0]       integ_limit;
      logic [15:0]       out_limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0] base_speed;
      logic [19:0] elapsed_us;
      logic [4:0]  sensor_hits;
   } item_type;

   typedef struct packed {
      logic signed [17:0] right_drive;
      logic signed [17:0] left_drive;
      logic signed [16:0] pid_out;
   } result_type;

endpackage

### hdl/lfps_engine.sv
`timescale 1ns / 1ps

module lfps_engine import lfps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       start,
   input  item_type   item,
   output logic       ready,
   input  logic       out_free,
   output logic       done,
   output result_type result
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b000000000001,
      ST_POS       = 12'b000000000010,
      ST_MUL_KI    = 12'b000000000100,
      ST_MUL_E     = 12'b000000001000,
      ST_INT_ADD   = 12'b000000010000,
      ST_INT_CLAMP = 12'b000000100000,
      ST_MUL_KP    = 12'b000001000000,
      ST_P_ADD     = 12'b000010000000,
      ST_MUL_KD    = 12'b000100000000,
      ST_DIV       = 12'b001000000000,
      ST_D_ADD     = 12'b010000000000,
      ST_OUT       = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic signed [3:0]  line_pos_ff, line_pos_in;
   logic signed [4:0]  prev_error_ff, prev_error_in;
   logic               side_now_ff, side_now_in;
   logic               side_prev_ff, side_prev_in;
   logic signed [47:0] integ_ff, integ_in;
   logic               err_neg_ff, err_neg_in;
   logic [3:0]         emag_ff, emag_in;
   logic               derr_neg_ff, derr_neg_in;
   logic [4:0]         dmag_ff, dmag_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        mcand_ff, mcand_in;
   logic [19:0]        mplier_ff, mplier_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [47:0] total_ff, total_in;

   // shared adder / subtractor
   logic [63:0] add_a, add_b, add_y;
   logic        add_sub;
   assign add_y = add_a + (add_sub ? ~add_b : add_b) + {63'b0, add_sub};

   logic signed [3:0]  lp_new;
   logic signed [4:0]  err_w, err_abs;
   logic signed [5:0]  derr_w, derr_abs;
   logic               side_new;
   logic [63:0]        mul_nxt;
   logic [21:0]        rem_sh;
   logic signed [47:0] iv, ilim, olim, sc, sc_abs;
   logic [15:0]        magv;
   logic signed [16:0] pid_w;

   always_comb begin
      priority if (item_ff.sensor_hits[4]) lp_new = POS_S5;
      else if (item_ff.sensor_hits[3]) lp_new = POS_S4;
      else if (item_ff.sensor_hits[2]) lp_new = POS_S3;
      else if (item_ff.sensor_hits[1]) lp_new = POS_S2;
      else if (item_ff.sensor_hits[0]) lp_new = POS_S1;
      else lp_new = line_pos_ff;
   end

   assign err_w    = {cfg.target_pos[3], cfg.target_pos} - {lp_new[3], lp_new};
   assign err_abs  = err_w[4] ? -err_w : err_w;
   assign derr_w   = {err_w[4], err_w} - {prev_error_ff[4], prev_error_ff};
   assign derr_abs = derr_w[5] ? -derr_w : derr_w;
   assign side_new = (lp_new > 4'sd0) ? 1'b1 : ((lp_new < 4'sd0) ? 1'b0 : side_now_ff);

   assign mul_nxt = mplier_ff[0] ? add_y : acc_ff;
   assign rem_sh  = {acc_ff[20:0], mcand_ff[36]};

   assign iv   = $signed(acc_ff[47:0]);
   assign ilim = $signed({16'b0, cfg.integ_limit, 16'b0});
   assign olim = $signed({16'b0, cfg.out_limit, 16'b0});
   assign sc   = (total_ff > olim) ? olim : ((total_ff < -olim) ? -olim : total_ff);
   assign sc_abs = sc[47] ? -sc : sc;
   assign magv   = sc_abs[31:16];
   assign pid_w  = sc[47] ? -$signed({1'b0, magv}) : $signed({1'b0, magv});

   assign result.pid_out     = pid_w;
   assign result.left_drive  = $signed({2'b0, item_ff.base_speed}) + {pid_w[16], pid_w};
   assign result.right_drive = $signed({2'b0, item_ff.base_speed}) - {pid_w[16], pid_w};

   assign ready = (state_ff == ST_IDLE);
   assign done  = (state_ff == ST_OUT) && out_free;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      line_pos_in   = line_pos_ff;
      prev_error_in = prev_error_ff;
      side_now_in   = side_now_ff;
      side_prev_in  = side_prev_ff;
      integ_in      = integ_ff;
      err_neg_in    = err_neg_ff;
      emag_in       = emag_ff;
      derr_neg_in   = derr_neg_ff;
      dmag_in       = dmag_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      add_a         = acc_ff;
      add_b         = mcand_ff;
      add_sub       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = item;
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            line_pos_in   = lp_new;
            prev_error_in = err_w;
            err_neg_in    = err_w[4];
            emag_in       = err_abs[3:0];
            derr_neg_in   = derr_w[5];
            dmag_in       = derr_abs[4:0];
            side_now_in   = side_new;
            side_prev_in  = side_new;
            if (side_new != side_prev_ff) begin
               integ_in = '0;
            end
            acc_in    = '0;
            mcand_in  = {24'b0, cfg.ki_gain};
            mplier_in = item_ff.elapsed_us;
            cnt_in    = STEPS_KI;
            state_in  = ST_MUL_KI;
         end
         ST_MUL_KI, ST_MUL_E, ST_MUL_KP, ST_MUL_KD: begin
            acc_in    = mul_nxt;
            mcand_in  = {mcand_ff[62:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[19:1]};
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               priority case (1'b1)
                  state_ff == ST_MUL_KI: begin
                     acc_in    = '0;
                     mcand_in  = mul_nxt;
                     mplier_in = {16'b0, emag_ff};
                     cnt_in    = STEPS_E;
                     state_in  = ST_MUL_E;
                  end
                  state_ff == ST_MUL_E: begin
                     state_in = ST_INT_ADD;
                  end
                  state_ff == ST_MUL_KP: begin
                     state_in = ST_P_ADD;
                  end
                  default: begin
                     mcand_in = mul_nxt;
                     acc_in   = '0;
                     cnt_in   = STEPS_DIV;
                     state_in = (item_ff.elapsed_us == '0) ? ST_OUT : ST_DIV;
                  end
               endcase
            end
         end
         ST_INT_ADD: begin
            add_a    = {{16{integ_ff[47]}}, integ_ff};
            add_b    = {25'b0, acc_ff[63:25]};
            add_sub  = err_neg_ff;
            acc_in   = add_y;
            state_in = ST_INT_CLAMP;
         end
         ST_INT_CLAMP: begin
            integ_in  = (iv > ilim) ? ilim : ((iv < -ilim) ? -ilim : iv);
            acc_in    = '0;
            mcand_in  = {32'b0, cfg.kp_gain};
            mplier_in = {16'b0, emag_ff};
            cnt_in    = STEPS_KP;
            state_in  = ST_MUL_KP;
         end
         ST_P_ADD: begin
            add_a     = {{16{integ_ff[47]}}, integ_ff};
            add_b     = {29'b0, acc_ff[35:1]};
            add_sub   = err_neg_ff;
            total_in  = $signed(add_y[47:0]);
            acc_in    = '0;
            mcand_in  = {32'b0, cfg.kd_gain};
            mplier_in = {15'b0, dmag_ff};
            cnt_in    = STEPS_KD;
            state_in  = ST_MUL_KD;
         end
         ST_DIV: begin
            // restoring divide: remainder in acc, dividend/quotient in mcand
            add_a   = {42'b0, rem_sh};
            add_b   = {43'b0, item_ff.elapsed_us, 1'b0};
            add_sub = 1'b1;
            if (!add_y[63]) begin
               acc_in   = {42'b0, add_y[21:0]};
               mcand_in = {27'b0, mcand_ff[35:0], 1'b1};
            end else begin
               acc_in   = {42'b0, rem_sh};
               mcand_in = {27'b0, mcand_ff[35:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = ST_D_ADD;
            end
         end
         ST_D_ADD: begin
            add_a    = {{16{total_ff[47]}}, total_ff};
            add_b    = {27'b0, mcand_ff[36:0]};
            add_sub  = derr_neg_ff;
            total_in = $signed(add_y[47:0]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         line_pos_ff   <= '0;
         prev_error_ff <= '0;
         side_now_ff   <= 1'b0;
         side_prev_ff  <= 1'b0;
         integ_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         line_pos_ff   <= line_pos_in;
         prev_error_ff <= prev_error_in;
         side_now_ff   <= side_now_in;
         side_prev_ff  <= side_prev_in;
         integ_ff      <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      err_neg_ff  <= err_neg_in;
      emag_ff     <= emag_in;
      derr_neg_ff <= derr_neg_in;
      dmag_ff     <= dmag_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      cnt_ff      <= cnt_in;
      total_ff    <= total_in;
   end

endmodule

### hdl/line_follow_pid_steering.sv
`timescale 1ns / 1ps
// Steering PID for a five-sensor line follower.
// req_ channel: one word per control step (sensor hits, elapsed microseconds,
// base speed). rsp_ channel: one word per step (clamped PID output and the
// left/right drives, base speed plus/minus the output).
// csr_ port: APB-style, 64-bit data, register i at byte address 8*i; write
// gains, target and limits only while no step is in flight.
// The derivative divide is skipped when elapsed_us is zero. All products are
// shift-add loops on one shared 64-bit adder (20 steps for Ki*dt, 4 for *|e|,
// 4 for Kp, 5 for Kd) and the derivative divide is a 37-step restoring loop on
// the same adder. One step is in flight at a time: a new word is accepted only
// once the last one has left the engine.
// The result sits in an output register; the next word is accepted while it
// waits. If rsp_tready stays low, the following step finishes its arithmetic
// and holds until the register frees.
// Reset restores the default gains, target and limits and clears line position,
// error history, side bits and integrator.

module line_follow_pid_steering import lfps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sensor_hits[4:0], elapsed_us[24:5], base_speed[40:25]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pid_out[16:0], left_drive[34:17], right_drive[52:35]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   item_type   item;
   result_type eng_result;
   logic       eng_ready, eng_done, out_free, csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[5:3])
            REG_TARGET_POS:  cfg_in.target_pos  = $signed(csr_pwdata[3:0]);
            REG_KP_GAIN:     cfg_in.kp_gain     = csr_pwdata[31:0];
            REG_KI_GAIN:     cfg_in.ki_gain     = csr_pwdata[39:0];
            REG_KD_GAIN:     cfg_in.kd_gain     = csr_pwdata[31:0];
            REG_INTEG_LIMIT: cfg_in.integ_limit = csr_pwdata[15:0];
            REG_OUT_LIMIT:   cfg_in.out_limit   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         REG_TARGET_POS:  csr_prdata = {60'b0, cfg_ff.target_pos};
         REG_KP_GAIN:     csr_prdata = {32'b0, cfg_ff.kp_gain};
         REG_KI_GAIN:     csr_prdata = {24'b0, cfg_ff.ki_gain};
         REG_KD_GAIN:     csr_prdata = {32'b0, cfg_ff.kd_gain};
         REG_INTEG_LIMIT: csr_prdata = {48'b0, cfg_ff.integ_limit};
         REG_OUT_LIMIT:   csr_prdata = {48'b0, cfg_ff.out_limit};
         default:         csr_prdata = '0;
      endcase
   end

   assign item.sensor_hits = req_tdata[4:0];
   assign item.elapsed_us  = req_tdata[24:5];
   assign item.base_speed  = req_tdata[40:25];

   assign req_tready = eng_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   lfps_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .start    (req_tvalid && eng_ready),
      .item     (item),
      .ready    (eng_ready),
      .out_free (out_free),
      .done     (eng_done),
      .result   (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff          <= 1'b0;
         cfg_ff.target_pos     <= TARGET_POS_RST;
         cfg_ff.kp_gain        <= KP_GAIN_RST;
         cfg_ff.ki_gain        <= KI_GAIN_RST;
         cfg_ff.kd_gain        <= KD_GAIN_RST;
         cfg_ff.integ_limit    <= INTEG_LIMIT_RST;
         cfg_ff.out_limit      <= OUT_LIMIT_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, rsp_data_ff.right_drive, rsp_data_ff.left_drive,
                        rsp_data_ff.pid_out};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a step is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over an undelivered word");

   a_pid_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.pid_out <= $signed({1'b0, cfg_ff.out_limit}))
                    && (rsp_data_ff.pid_out >= -$signed({1'b0, cfg_ff.out_limit})))
      else $error("pid_out outside the output limit");

   a_drive_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.left_drive - rsp_data_ff.right_drive
                        == {rsp_data_ff.pid_out, 1'b0}))
      else $error("left and right drives disagree with pid_out");

endmodule
